FILE: hdl/ftdt_pkg.sv
// Shared types and constants for the float to decimal text block.
// Used by ftdt_ctrl, ftdt_datapath and float_to_decimal_text; depends on nothing.
`default_nettype none
package ftdt_pkg;

  localparam int MAX_FRAC_DIGITS = 9;
  localparam int DIGIT_W         = 4;
  localparam int BCD_DIGITS      = 19;
  localparam int BCD_W           = BCD_DIGITS * 4;
  localparam int BIN_W           = 64;
  localparam int PROD_W          = 61;
  localparam int MCAND_W         = 31;
  localparam int P10_W           = 30;
  localparam int BITS_PER_STEP   = 4;
  localparam int CONV_STEPS      = BIN_W / BITS_PER_STEP;
  localparam int CONV_CNT_W      = $clog2(CONV_STEPS);
  localparam int POS_W           = $clog2(BCD_DIGITS);

  localparam logic [MCAND_W-1:0] SAT_VALUE = 31'h7FFF_FFFF;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_POINT = 7'h2E;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic shift;
    logic conv;
    logic find;
    logic emit_sign;
    logic emit_digit;
    logic emit_point;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic neg;
    logic d_zero;
    logic pos_zero;
    logic pos_at_d;
    logic out_free;
  } sts_t;

  // powers of ten for the clamped digit count
  function automatic logic [P10_W-1:0] pow10(input logic [DIGIT_W-1:0] d);
    logic [P10_W-1:0] p;
    case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ftdt_ctrl.sv
// Sequencing state machine for the float to decimal text block.
// Depends on ftdt_pkg; drives ftdt_datapath through cmd_t and reads sts_t.
`default_nettype none
module ftdt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ftdt_pkg::sts_t sts,
  output ftdt_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_SIGN  = 3'd5;
  localparam logic [2:0] S_DIGIT = 3'd6;
  localparam logic [2:0] S_POINT = 3'd7;

  logic [2:0] state, state_next;
  logic [ftdt_pkg::CONV_CNT_W-1:0] cnt, cnt_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        cnt_next   = '0;
        state_next = S_CONV;
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == ftdt_pkg::CONV_CNT_W'(ftdt_pkg::CONV_STEPS - 1)) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = sts.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.pos_zero) begin
            state_next = S_IDLE;
          end else if (sts.pos_at_d && !sts.d_zero) begin
            state_next = S_POINT;
          end
        end
      end
      S_POINT: begin
        if (sts.out_free) begin
          cmd.emit_point = 1'b1;
          state_next     = S_DIGIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/ftdt_datapath.sv
// Datapath: float decode, scaling multiply, rounding shift, binary to BCD
// conversion and the character output register. Depends on ftdt_pkg.
`default_nettype none
module ftdt_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ftdt_pkg::cmd_t                cmd,
  output ftdt_pkg::sts_t                     sts,
  input  wire logic [31:0]                   value_bits,
  input  wire logic [ftdt_pkg::DIGIT_W-1:0]  d_cfg,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [6:0]                         out_char,
  output logic                               last_char,
  output logic                               saturated
);

  localparam int CV_W = ftdt_pkg::BCD_W + ftdt_pkg::BIN_W;

  logic [ftdt_pkg::DIGIT_W-1:0]  d;
  logic                          sat, neg, go_left;
  logic [ftdt_pkg::MCAND_W-1:0]  mcand;
  logic [2:0]                    lsh;
  logic [5:0]                    rsh;
  logic [ftdt_pkg::PROD_W-1:0]   prod;
  logic [CV_W-1:0]               cv;
  logic [ftdt_pkg::POS_W-1:0]    pos;

  // decode fields of the incoming float
  logic [7:0]  expf;
  logic [22:0] frac;
  logic        sign;
  logic        sat_in, neg_in;
  logic [7:0]  rsh_raw;
  assign sign    = value_bits[31];
  assign expf    = value_bits[30:23];
  assign frac    = value_bits[22:0];
  assign sat_in  = (expf == 8'hFF) || (expf >= 8'd158);
  assign neg_in  = sign && !(expf == 8'h00 && frac == 23'd0) && !(expf == 8'hFF && frac != 23'd0);
  assign rsh_raw = (expf == 8'h00) ? 8'd149 : (8'd150 - expf);

  // rounding shift of the product
  logic [ftdt_pkg::BIN_W-1:0] wide, scaled;
  assign wide = {{(ftdt_pkg::BIN_W - ftdt_pkg::PROD_W){1'b0}}, prod};
  always_comb begin
    if (go_left) begin
      scaled = wide << lsh;
    end else begin
      scaled = (wide >> rsh) + {{(ftdt_pkg::BIN_W - 1){1'b0}}, wide[rsh - 6'd1]};
    end
  end

  // four double-dabble bit steps per cycle
  function automatic logic [CV_W-1:0] dabble(input logic [CV_W-1:0] v);
    logic [CV_W-1:0] t;
    t = v;
    for (int s = 0; s < ftdt_pkg::BITS_PER_STEP; s++) begin
      for (int k = 0; k < ftdt_pkg::BCD_DIGITS; k++) begin
        if (t[ftdt_pkg::BIN_W + 4*k +: 4] >= 4'd5) begin
          t[ftdt_pkg::BIN_W + 4*k +: 4] = t[ftdt_pkg::BIN_W + 4*k +: 4] + 4'd3;
        end
      end
      t = t << 1;
    end
    return t;
  endfunction

  logic [ftdt_pkg::BCD_DIGITS-1:0][3:0] digits;
  assign digits = cv[CV_W-1 -: ftdt_pkg::BCD_W];

  // highest nonzero digit, never below the point
  logic [ftdt_pkg::POS_W-1:0] top, start;
  always_comb begin
    top = '0;
    for (int k = 0; k < ftdt_pkg::BCD_DIGITS; k++) begin
      if (digits[k] != 4'd0) begin
        top = ftdt_pkg::POS_W'(k);
      end
    end
    start = (top > {1'b0, d}) ? top : {1'b0, d};
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d       <= (d_cfg > 4'(ftdt_pkg::MAX_FRAC_DIGITS)) ? 4'(ftdt_pkg::MAX_FRAC_DIGITS) : d_cfg;
      sat     <= sat_in;
      neg     <= neg_in;
      go_left <= sat_in || (expf >= 8'd150);
      lsh     <= sat_in ? 3'd0 : 3'(expf - 8'd150);
      rsh     <= (rsh_raw > 8'd63) ? 6'd63 : rsh_raw[5:0];
      if (sat_in) begin
        mcand <= ftdt_pkg::SAT_VALUE;
      end else if (expf == 8'h00) begin
        mcand <= {8'd0, frac};
      end else begin
        mcand <= {7'd0, 1'b1, frac};
      end
    end
    if (cmd.mul) begin
      prod <= {{(ftdt_pkg::PROD_W - ftdt_pkg::MCAND_W){1'b0}}, mcand} *
              {{(ftdt_pkg::PROD_W - ftdt_pkg::P10_W){1'b0}}, ftdt_pkg::pow10(d)};
    end
    if (cmd.shift) begin
      cv <= {{ftdt_pkg::BCD_W{1'b0}}, scaled};
    end else if (cmd.conv) begin
      cv <= dabble(cv);
    end
    if (cmd.find) begin
      pos <= start;
    end else if (cmd.emit_digit && pos != '0) begin
      pos <= pos - 1'b1;
    end
  end

  // character output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit || cmd.emit_point) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char  <= ftdt_pkg::CHAR_MINUS;
      last_char <= 1'b0;
      saturated <= sat;
    end else if (cmd.emit_point) begin
      out_char  <= ftdt_pkg::CHAR_POINT;
      last_char <= 1'b0;
      saturated <= sat;
    end else if (cmd.emit_digit) begin
      out_char  <= ftdt_pkg::CHAR_ZERO + {3'd0, digits[pos]};
      last_char <= (pos == '0);
      saturated <= sat;
    end
  end

  // status back to the controller
  assign sts.neg      = neg;
  assign sts.d_zero   = (d == '0);
  assign sts.pos_zero = (pos == '0);
  assign sts.pos_at_d = (pos == {1'b0, d});
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: hdl/float_to_decimal_text.sv
// Top level of the float to decimal text block: config register, controller
// and datapath. Depends on ftdt_pkg, ftdt_ctrl and ftdt_datapath.
`default_nettype none
// Prints one IEEE single-precision value as ASCII, one character per output
// beat: an optional '-', the integer digits (at least one), and when
// frac_digits is above zero a '.' and that many fraction digits, rounded half
// up on the exact value. last_char marks the final character; saturated is
// set on every character of a value of magnitude 2^31 or more, an infinity or
// a NaN, which print as 2147483647. frac_digits above 9 acts as 9 and should
// be written only while the block is idle. Each value goes through load,
// scaling multiply, rounding shift, binary to BCD conversion at four bits
// per cycle and digit search, then emits its characters whenever the output
// register is free; a new value is taken only after its last character.
module float_to_decimal_text (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             last_char,
  output logic             saturated,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  frac_digits
);

  ftdt_pkg::cmd_t cmd;
  ftdt_pkg::sts_t sts;
  logic [ftdt_pkg::DIGIT_W-1:0] frac_digits_reg;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_digits_reg <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      frac_digits_reg <= frac_digits;
    end
  end

  ftdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftdt_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value_bits (value_bits),
    .d_cfg      (frac_digits_reg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_char  (last_char),
    .saturated  (saturated)
  );

  // one value at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a value is in progress");

  // characters are only sign, point or digits
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char == ftdt_pkg::CHAR_MINUS || out_char == ftdt_pkg::CHAR_POINT ||
                   (out_char >= ftdt_pkg::CHAR_ZERO && out_char <= ftdt_pkg::CHAR_NINE)))
    else $error("output character outside the printable set");

  // emits happen only when the output register can take them
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit || cmd.emit_point) |-> (!out_valid || out_ready))
    else $error("pending character overwritten");

  // the final character returns the controller to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit && sts.pos_zero |=> in_ready && last_char)
    else $error("final character did not end the value");

endmodule
`default_nettype wire
